### rtl/i2r_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and symbol tables for the integer to Roman numeral unit.
// No dependencies; used by i2r_ctrl, i2r_datapath and the top level.

package i2r_pkg;

  localparam int unsigned NumW   = 12;
  localparam int unsigned CharW  = 8;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned EntW   = 4;
  localparam int unsigned NumEnt = 13;
  localparam int unsigned InTdataW  = 16;
  localparam int unsigned OutTdataW = 16;

  localparam logic [NumW-1:0] LimitValue = 12'd3999;

  // Symbol indexes.
  localparam logic [IdxW-1:0] SymI = 3'd0;
  localparam logic [IdxW-1:0] SymV = 3'd1;
  localparam logic [IdxW-1:0] SymX = 3'd2;
  localparam logic [IdxW-1:0] SymL = 3'd3;
  localparam logic [IdxW-1:0] SymC = 3'd4;
  localparam logic [IdxW-1:0] SymD = 3'd5;
  localparam logic [IdxW-1:0] SymM = 3'd6;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } i2r_state_e;

  typedef struct packed {
    logic load;
    logic step;
  } i2r_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic final_sym;
  } i2r_status_t;

  // ASCII code of a symbol index.
  function automatic logic [CharW-1:0] sym_char(input logic [IdxW-1:0] idx);
    logic [CharW-1:0] c;
    case (idx)
      SymI:    c = 8'h49;
      SymV:    c = 8'h56;
      SymX:    c = 8'h58;
      SymL:    c = 8'h4C;
      SymC:    c = 8'h43;
      SymD:    c = 8'h44;
      SymM:    c = 8'h4D;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Greedy table, largest first: M CM D CD C XC L XL X IX V IV I.
  function automatic logic [NumW-1:0] ent_value(input logic [EntW-1:0] e);
    logic [NumW-1:0] v;
    case (e)
      4'd0:    v = 12'd1000;
      4'd1:    v = 12'd900;
      4'd2:    v = 12'd500;
      4'd3:    v = 12'd400;
      4'd4:    v = 12'd100;
      4'd5:    v = 12'd90;
      4'd6:    v = 12'd50;
      4'd7:    v = 12'd40;
      4'd8:    v = 12'd10;
      4'd9:    v = 12'd9;
      4'd10:   v = 12'd5;
      4'd11:   v = 12'd4;
      default: v = 12'd1;
    endcase
    return v;
  endfunction

  // Odd entries are the subtractive pairs.
  function automatic logic ent_pair(input logic [EntW-1:0] e);
    return e[0] && (e != 4'd13) && (e != 4'd15);
  endfunction

  function automatic logic [IdxW-1:0] ent_sym1(input logic [EntW-1:0] e);
    logic [IdxW-1:0] s;
    case (e)
      4'd0:    s = SymM;
      4'd1:    s = SymC;
      4'd2:    s = SymD;
      4'd3:    s = SymC;
      4'd4:    s = SymC;
      4'd5:    s = SymX;
      4'd6:    s = SymL;
      4'd7:    s = SymX;
      4'd8:    s = SymX;
      4'd9:    s = SymI;
      4'd10:   s = SymV;
      4'd11:   s = SymI;
      default: s = SymI;
    endcase
    return s;
  endfunction

  function automatic logic [IdxW-1:0] ent_sym2(input logic [EntW-1:0] e);
    logic [IdxW-1:0] s;
    case (e)
      4'd1:    s = SymM;
      4'd3:    s = SymD;
      4'd5:    s = SymC;
      4'd7:    s = SymL;
      4'd9:    s = SymX;
      4'd11:   s = SymV;
      default: s = SymI;
    endcase
    return s;
  endfunction

  // Largest table entry not above the value; the value is at least one here.
  function automatic logic [EntW-1:0] best_ent(input logic [NumW-1:0] v);
    logic [EntW-1:0] e;
    e = EntW'(NumEnt - 1);
    for (int i = NumEnt - 1; i >= 0; i--) begin
      if (v >= ent_value(EntW'(i))) begin
        e = EntW'(i);
      end
    end
    return e;
  endfunction

endpackage

### rtl/i2r_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: takes a request, then steps the datapath once per symbol.
// Depends on i2r_pkg.

module i2r_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  i2r_pkg::i2r_status_t  status_i,
  output i2r_pkg::i2r_cmd_t     cmd_o
);

  i2r_pkg::i2r_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= i2r_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      i2r_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = i2r_pkg::ST_RUN;
        end
      end
      i2r_pkg::ST_RUN: begin
        if (status_i.slot_free && status_i.final_sym) begin
          state_d = i2r_pkg::ST_IDLE;
        end
      end
      default: state_d = i2r_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      i2r_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      i2r_pkg::ST_RUN: begin
        cmd_o.step = status_i.slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

### rtl/i2r_datapath.sv
`timescale 1ns / 1ps
// Datapath: remainder register, greedy table lookup and the output register.
// Depends on i2r_pkg.

module i2r_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [i2r_pkg::NumW-1:0]       number_i,
  input  i2r_pkg::i2r_cmd_t              cmd_i,
  output i2r_pkg::i2r_status_t           status_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [i2r_pkg::CharW-1:0]      symbol_char_o,
  output logic [i2r_pkg::IdxW-1:0]       symbol_index_o,
  output logic                           last_symbol_o,
  output logic                           invalid_input_o
);

  logic [i2r_pkg::NumW-1:0]  rem_q, rem_d;
  logic [i2r_pkg::EntW-1:0]  ent_q, ent_d;
  logic                      half_q, half_d;
  logic                      invalid_q, invalid_d;
  logic                      out_valid_q, out_valid_d;
  logic [i2r_pkg::CharW-1:0] char_q, char_d;
  logic [i2r_pkg::IdxW-1:0]  idx_q, idx_d;
  logic                      last_q, last_d;
  logic                      inv_q, inv_d;

  logic [i2r_pkg::EntW-1:0]  cur_ent;
  logic [i2r_pkg::NumW-1:0]  cur_val;
  logic [i2r_pkg::IdxW-1:0]  cur_sym;
  logic                      completes;
  logic                      final_sym;

  // In the second half of a pair the entry is held; otherwise pick the largest fit.
  assign cur_ent   = half_q ? ent_q : i2r_pkg::best_ent(rem_q);
  assign cur_val   = i2r_pkg::ent_value(cur_ent);
  assign cur_sym   = half_q ? i2r_pkg::ent_sym2(ent_q) : i2r_pkg::ent_sym1(cur_ent);
  assign completes = half_q || !i2r_pkg::ent_pair(cur_ent);
  assign final_sym = invalid_q || (completes && (rem_q == cur_val));

  assign status_o.slot_free = !out_valid_q || out_ready_i;
  assign status_o.final_sym = final_sym;

  always_comb begin
    rem_d       = rem_q;
    ent_d       = ent_q;
    half_d      = half_q;
    invalid_d   = invalid_q;
    char_d      = char_q;
    idx_d       = idx_q;
    last_d      = last_q;
    inv_d       = inv_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.load) begin
      rem_d     = number_i;
      half_d    = 1'b0;
      invalid_d = (number_i == '0) || (number_i > i2r_pkg::LimitValue);
    end else if (cmd_i.step) begin
      out_valid_d = 1'b1;
      last_d      = final_sym;
      if (invalid_q) begin
        char_d = '0;
        idx_d  = '0;
        inv_d  = 1'b1;
      end else begin
        char_d = i2r_pkg::sym_char(cur_sym);
        idx_d  = cur_sym;
        inv_d  = 1'b0;
        if (completes) begin
          rem_d  = rem_q - cur_val;
          half_d = 1'b0;
        end else begin
          ent_d  = cur_ent;
          half_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      half_q      <= 1'b0;
      invalid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      half_q      <= half_d;
      invalid_q   <= invalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q  <= ent_d;
    char_q <= char_d;
    idx_q  <= idx_d;
    last_q <= last_d;
    inv_q  <= inv_d;
  end

  assign out_valid_o     = out_valid_q;
  assign symbol_char_o   = char_q;
  assign symbol_index_o  = idx_q;
  assign last_symbol_o   = last_q;
  assign invalid_input_o = inv_q;

`ifndef NO_ASSERTIONS
  // A pair is never started for an out-of-range number.
  assert property (@(posedge clk_i) disable iff (!rst_ni) half_q |-> !invalid_q)
    else $error("pair in progress on an invalid number");

  // The second symbol of a pair always closes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && half_q) |=> !half_q)
    else $error("pair not closed after its second symbol");

  // An invalid result carries zero data and ends its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && inv_q) |-> (last_q && char_q == '0 && idx_q == '0))
    else $error("invalid result with nonzero symbol or no last mark");

  // The remainder of a valid number stays within range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !invalid_q |-> (rem_q <= i2r_pkg::LimitValue))
    else $error("remainder out of range");
`endif

endmodule

### rtl/integer_to_roman_numeral_unit.sv
`timescale 1ns / 1ps
// Top level of the integer to Roman numeral unit: controller plus datapath.
// Depends on i2r_pkg, i2r_ctrl and i2r_datapath.
//
//   Channel  Dir  Group    Contents
//   s_axis   in   request  tdata[11:0] number
//   m_axis   out  symbol   tdata[7:0] symbol_char, tdata[10:8] symbol_index,
//                          tlast last_symbol, tuser invalid_input
//
// A request is loaded, then the datapath is stepped once per symbol: 1 to 15
// symbols per number. The symbol emitter produces one symbol per cycle while
// the output is not stalled. An out-of-range number gives one result.
// Reset clears the controller and the output valid flag at once.
// A stalled output holds the emitter; a new request is taken as soon as the
// last symbol sits in the output register.

module integer_to_roman_numeral_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [i2r_pkg::InTdataW-1:0]      s_axis_tdata_i,  // [11:0] number
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [i2r_pkg::OutTdataW-1:0]     m_axis_tdata_o,  // [7:0] symbol_char, [10:8] symbol_index
  output logic                              m_axis_tlast_o,  // last_symbol
  output logic                              m_axis_tuser_o   // invalid_input
);

  i2r_pkg::i2r_cmd_t         cmd;
  i2r_pkg::i2r_status_t      status;
  logic [i2r_pkg::CharW-1:0] symbol_char;
  logic [i2r_pkg::IdxW-1:0]  symbol_index;

  i2r_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  i2r_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .number_i        (s_axis_tdata_i[i2r_pkg::NumW-1:0]),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .symbol_char_o   (symbol_char),
    .symbol_index_o  (symbol_index),
    .last_symbol_o   (m_axis_tlast_o),
    .invalid_input_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {
    {(i2r_pkg::OutTdataW - i2r_pkg::CharW - i2r_pkg::IdxW){1'b0}},
    symbol_index,
    symbol_char
  };

endmodule

### dv/tb_integer_to_roman_numeral_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for integer_to_roman_numeral_unit: a directed table, then random numbers.
// Symbols are checked against a behavioral builder or a typed row. Depends on i2r_pkg and the RTL.

module tb_integer_to_roman_numeral_unit;

  localparam int unsigned InPadW  = i2r_pkg::InTdataW - i2r_pkg::NumW;
  localparam int unsigned OutPadW = i2r_pkg::OutTdataW - i2r_pkg::CharW - i2r_pkg::IdxW;
  localparam int unsigned NumDirected = 25;
  localparam int unsigned NumRandom   = 125;
  localparam int unsigned MaxReported = 10;

  // ASCII glyphs packed by symbol index, index 0 in the lowest byte.
  localparam logic [8*7-1:0] Glyphs = "MDCLXVI";

  typedef struct packed {
    logic [i2r_pkg::CharW-1:0] ch;
    logic [i2r_pkg::IdxW-1:0]  idx;
    logic                      last;
    logic                      inv;
  } symbol_t;

  // A directed row either carries its single expected symbol or leaves it to the builder.
  typedef struct packed {
    logic [i2r_pkg::NumW-1:0]  number;
    logic                      typed;
    logic [i2r_pkg::CharW-1:0] ch;
    logic [i2r_pkg::IdxW-1:0]  idx;
    logic                      inv;
  } directed_row_t;

  localparam directed_row_t DirectedRows [NumDirected] = '{
    '{12'd0,    1'b1, 8'h00, i2r_pkg::SymI, 1'b1},
    '{12'd4000, 1'b1, 8'h00, i2r_pkg::SymI, 1'b1},
    '{12'd4095, 1'b1, 8'h00, i2r_pkg::SymI, 1'b1},
    '{12'd1,    1'b1, "I",   i2r_pkg::SymI, 1'b0},
    '{12'd5,    1'b1, "V",   i2r_pkg::SymV, 1'b0},
    '{12'd10,   1'b1, "X",   i2r_pkg::SymX, 1'b0},
    '{12'd50,   1'b1, "L",   i2r_pkg::SymL, 1'b0},
    '{12'd100,  1'b1, "C",   i2r_pkg::SymC, 1'b0},
    '{12'd500,  1'b1, "D",   i2r_pkg::SymD, 1'b0},
    '{12'd1000, 1'b1, "M",   i2r_pkg::SymM, 1'b0},
    '{12'd3999, 1'b0, 8'h00, i2r_pkg::SymI, 1'b0},
    '{12'd3888, 1'b0, 8'h00, i2r_pkg::SymI, 1'b0},
    '{12'd2,    1'b0, 8'h00, i2r_pkg::SymI, 1'b0},
    '{12'd3,    1'b0, 8'h00, i2r_pkg::SymI, 1'b0},
    '{12'd4,    1'b0, 8'h00, i2r_pkg::SymI, 1'b0},
    '{12'd9,    1'b0, 8'h00, i2r_pkg::SymI, 1'b0},
    '{12'd14,   1'b0, 8'h00, i2r_pkg::SymI, 1'b0},
    '{12'd40,   1'b0, 8'h00, i2r_pkg::SymI, 1'b0},
    '{12'd90,   1'b0, 8'h00, i2r_pkg::SymI, 1'b0},
    '{12'd400,  1'b0, 8'h00, i2r_pkg::SymI, 1'b0},
    '{12'd900,  1'b0, 8'h00, i2r_pkg::SymI, 1'b0},
    '{12'd1994, 1'b0, 8'h00, i2r_pkg::SymI, 1'b0},
    '{12'd444,  1'b0, 8'h00, i2r_pkg::SymI, 1'b0},
    '{12'd2048, 1'b0, 8'h00, i2r_pkg::SymI, 1'b0},
    '{12'd3000, 1'b0, 8'h00, i2r_pkg::SymI, 1'b0}
  };

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid_i = 1'b0;
  logic                          s_axis_tready_o;
  logic [i2r_pkg::InTdataW-1:0]  s_axis_tdata_i = '0;   // [11:0] number
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i = 1'b0;
  logic [i2r_pkg::OutTdataW-1:0] m_axis_tdata_o;        // [7:0] symbol_char, [10:8] symbol_index
  logic                          m_axis_tlast_o;        // last_symbol
  logic                          m_axis_tuser_o;        // invalid_input

  symbol_t expected_symbols[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;

  integer_to_roman_numeral_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Builds the numeral of one number, largest symbol first, and queues its symbols.
  task automatic predict_numeral(input logic [i2r_pkg::NumW-1:0] number);
    logic [i2r_pkg::IdxW-1:0] run[$];
    logic [i2r_pkg::IdxW-1:0] unit;
    symbol_t sym;
    int unsigned scale;
    int unsigned digit;
    if (number == 0 || number > 3999) begin
      sym = '{ch: 8'h00, idx: i2r_pkg::SymI, last: 1'b1, inv: 1'b1};
      expected_symbols.push_back(sym);
      return;
    end
    for (int k = 0; k < number / 1000; k++) run.push_back(i2r_pkg::SymM);
    scale = 100;
    unit = i2r_pkg::SymC;
    repeat (3) begin
      digit = (number / scale) % 10;
      if (digit == 9) begin
        run.push_back(unit);
        run.push_back(unit + 3'd2);
      end else if (digit == 4) begin
        run.push_back(unit);
        run.push_back(unit + 3'd1);
      end else begin
        if (digit >= 5) begin
          run.push_back(unit + 3'd1);
          digit -= 5;
        end
        repeat (digit) run.push_back(unit);
      end
      scale /= 10;
      unit -= 3'd2;
    end
    foreach (run[k]) begin
      sym.ch   = Glyphs[run[k]*8 +: 8];
      sym.idx  = run[k];
      sym.last = (k == run.size() - 1);
      sym.inv  = 1'b0;
      expected_symbols.push_back(sym);
    end
  endtask

  // Offers one request; the expectation is queued when the request is taken.
  task automatic send_number(input logic [i2r_pkg::NumW-1:0] number, input logic typed,
                             input symbol_t typed_sym);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {{InPadW{1'b0}}, number};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (typed) expected_symbols.push_back(typed_sym);
    else predict_numeral(number);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    m_axis_tready_i = ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    symbol_t got;
    symbol_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = '{ch: m_axis_tdata_o[i2r_pkg::CharW-1:0],
              idx: m_axis_tdata_o[i2r_pkg::CharW +: i2r_pkg::IdxW],
              last: m_axis_tlast_o, inv: m_axis_tuser_o};
      if (expected_symbols.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReported)
          $display("unexpected symbol: char %h idx %0d last %b invalid %b",
                   got.ch, got.idx, got.last, got.inv);
      end else begin
        want = expected_symbols.pop_front();
        if (got !== want || m_axis_tdata_o[i2r_pkg::OutTdataW-1 -: OutPadW] !== '0) begin
          mismatch_count++;
          if (mismatch_count <= MaxReported)
            $display({"symbol mismatch: expected char %h idx %0d last %b invalid %b, ",
                      "got char %h idx %0d last %b invalid %b pad %h"},
                     want.ch, want.idx, want.last, want.inv,
                     got.ch, got.idx, got.last, got.inv,
                     m_axis_tdata_o[i2r_pkg::OutTdataW-1 -: OutPadW]);
        end
      end
    end
  end

  initial begin
    symbol_t typed_sym;
    logic [i2r_pkg::NumW-1:0] number;
    int unsigned drained;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (DirectedRows[r]) begin
      typed_sym = '{ch: DirectedRows[r].ch, idx: DirectedRows[r].idx, last: 1'b1,
                    inv: DirectedRows[r].inv};
      send_number(DirectedRows[r].number, DirectedRows[r].typed, typed_sym);
    end

    // Four stretches: free flowing, sparse requests, a slow receiver, and both at once.
    for (int n = 0; n < NumRandom; n++) begin
      case (n * 4 / NumRandom)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      if ($urandom_range(99) < 85) number = i2r_pkg::NumW'($urandom_range(3999, 1));
      else if ($urandom_range(1) == 0) number = '0;
      else number = i2r_pkg::NumW'($urandom_range(4095, 4000));
      send_number(number, 1'b0, '0);
    end
    s_axis_tvalid_i = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;

    while (expected_symbols.size() != 0) @(posedge clk_i);
    // Any stray symbol after the last expected one shows up within a numeral's length.
    drained = 0;
    while (drained < 40) begin
      @(posedge clk_i);
      drained++;
    end

    if (mismatch_count == 0 && expected_symbols.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
